// File: rtl/core/box_avg_pkg.sv
package box_avg_pkg;

  localparam int PIX_W   = 16;
  localparam int SCALE_W = 5;
  localparam int DIM_W   = 14;
  localparam int CFG_W   = 14;
  localparam int POS_W   = 13;
  localparam int SUB_W   = 4;
  localparam int DIV_W   = 9;   // s*s, up to 256
  localparam int REM_W   = 8;
  localparam int LANES   = 3;

  localparam logic [SCALE_W-1:0] SCALE_MAX   = 5'd16;
  localparam logic [DIM_W-1:0]   DIM_MAX     = 14'd8192;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd8;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 14'd4096;

  // configuration register indexes
  localparam logic [1:0] CFG_SCALE  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic col_write;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic seg_end;
    logic blk_out;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/box_average_downscaler_core.sv
// Box-average downscaler: RGB pixels in raster order are reduced by an integer factor
// (scale_factor, 1..16) in both directions, each result being the per-channel mean of one
// scale-by-scale block, truncated. Partial blocks at the right and bottom edges are dropped,
// and output columns beyond MAX_OUT_WIDTH are dropped too. One item is handled at a time:
// a pixel that does not end a block is accepted, then goes through the column-sum memory
// read-modify-write; a pixel that completes a block is accepted, then its block sum is
// divided by scale squared in the one-bit-per-cycle divider, and it waits for any previous
// result to leave the output register. A write to the scale, width or height register
// restarts the frame; out_tlast marks the end of an output row, out_tuser the frame end.
module box_average_downscaler_core #(
  parameter int MAX_OUT_WIDTH = 4096,
  parameter int PIXEL_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // pixel_red, pixel_green, pixel_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // mean_red, mean_green, mean_blue
  output logic        out_tlast,    // row_end
  output logic [0:0]  out_tuser,    // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [box_avg_pkg::CFG_W-1:0] cfg_wdata
);
  import box_avg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  box_avg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  box_avg_dp #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous one still in progress");

  // frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without row end");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");
`endif

endmodule

// File: rtl/core/box_avg_ram.sv
module box_avg_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/box_avg_div.sv
module box_avg_div #(
  parameter int SUM_W = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [box_avg_pkg::LANES-1:0][SUM_W-1:0] dividend,
  input  logic [box_avg_pkg::DIV_W-1:0]          divisor,
  output logic [box_avg_pkg::LANES-1:0][SUM_W-1:0] quotient,
  output logic                                   done
);
  import box_avg_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [LANES-1:0][SUM_W-1:0]     q_r, q_nxt;
  logic [LANES-1:0][REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]                d_r;

  // restoring division, one quotient bit per cycle, three lanes side by side
  always_comb begin
    logic [DIV_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_r[l], q_r[l][SUM_W-1]};
      if (trial >= d_r) begin
        rem_nxt[l] = REM_W'(trial - d_r);
        q_nxt[l]   = {q_r[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[REM_W-1:0];
        q_nxt[l]   = {q_r[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = (cnt_r == '0);

endmodule

// File: rtl/core/box_avg_dp.sv
module box_avg_dp #(
  parameter int MAX_OUT_WIDTH = 4096,
  parameter int PIXEL_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  box_avg_pkg::cmd_t         cmd,
  output box_avg_pkg::sts_t         sts,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [box_avg_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [47:0]               in_tdata,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [47:0]               out_tdata,
  output logic                      out_tlast,
  output logic [0:0]                out_tuser
);
  import box_avg_pkg::*;

  localparam int SUM_W = PIXEL_BITS + 8;
  localparam int AW    = $clog2(MAX_OUT_WIDTH);
  localparam logic [PIX_W-1:0] PIX_MASK =
    (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  // configuration
  logic [SCALE_W-1:0] scale_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [SCALE_W-1:0] s_eff;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               restart;

  // position of the next item
  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt, oc_r, oc_nxt;
  logic [SUB_W-1:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [DIM_W-1:0] cbase_r, cbase_nxt, rbase_r, rbase_nxt;

  logic ix_first, ix_last, iy_first, iy_last, in_block, oc_ok;
  logic col_last_blk, row_last_blk;
  logic [DIM_W:0] s_ext;

  // snapshot of the accepted item
  logic          seg_q, iy_first_q, iy_last_q, rowend_q, frmend_q;
  logic [AW-1:0] addr_q;

  logic [LANES-1:0][SUM_W-1:0] pix, rs_r, rs_nxt, rd_lanes, wr_lanes, dvd, quot;
  logic [LANES*SUM_W-1:0]      rd_data;
  logic                        div_done;
  logic [DIV_W-1:0]            divisor;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_last_r, out_frame_r;

  assign restart = cfg_we &&
    (cfg_index == CFG_SCALE || cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (scale_r == '0) ? SCALE_W'(1) : (scale_r > SCALE_MAX) ? SCALE_MAX : scale_r;
    w_eff = (width_r == '0) ? DIM_W'(1) : (width_r > DIM_MAX) ? DIM_MAX : width_r;
    h_eff = (height_r == '0) ? DIM_W'(1) : (height_r > DIM_MAX) ? DIM_MAX : height_r;
  end

  // block geometry without any division: a block counts only if it fits whole
  always_comb begin
    s_ext        = (DIM_W+1)'(s_eff);
    ix_first     = (ix_r == '0);
    iy_first     = (iy_r == '0);
    ix_last      = ({1'b0, ix_r} == s_eff - 1'b1);
    iy_last      = ({1'b0, iy_r} == s_eff - 1'b1);
    oc_ok        = ((DIM_W)'(oc_r) < DIM_W'(MAX_OUT_WIDTH));
    in_block     = oc_ok && ({1'b0, cbase_r} + s_ext <= {1'b0, w_eff})
                         && ({1'b0, rbase_r} + s_ext <= {1'b0, h_eff});
    col_last_blk = (oc_r == POS_W'(MAX_OUT_WIDTH - 1)) ||
                   ({1'b0, cbase_r} + (s_ext << 1) > {1'b0, w_eff});
    row_last_blk = ({1'b0, rbase_r} + (s_ext << 1) > {1'b0, h_eff});
  end

  always_comb begin
    col_nxt   = col_r;
    ix_nxt    = ix_r;
    oc_nxt    = oc_r;
    cbase_nxt = cbase_r;
    row_nxt   = row_r;
    iy_nxt    = iy_r;
    rbase_nxt = rbase_r;
    if (restart) begin
      col_nxt   = '0;
      ix_nxt    = '0;
      oc_nxt    = '0;
      cbase_nxt = '0;
      row_nxt   = '0;
      iy_nxt    = '0;
      rbase_nxt = '0;
    end else if (cmd.accept) begin
      if (DIM_W'(col_r) + DIM_W'(1) >= w_eff) begin
        col_nxt   = '0;
        ix_nxt    = '0;
        oc_nxt    = '0;
        cbase_nxt = '0;
        if (DIM_W'(row_r) + DIM_W'(1) >= h_eff) begin
          row_nxt   = '0;
          iy_nxt    = '0;
          rbase_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
          if (iy_last) begin
            iy_nxt    = '0;
            rbase_nxt = rbase_r + DIM_W'(s_eff);
          end else begin
            iy_nxt = iy_r + 1'b1;
          end
        end
      end else begin
        col_nxt = col_r + 1'b1;
        if (ix_last) begin
          ix_nxt    = '0;
          oc_nxt    = oc_r + 1'b1;
          cbase_nxt = cbase_r + DIM_W'(s_eff);
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      ix_r    <= '0;
      oc_r    <= '0;
      cbase_r <= '0;
      row_r   <= '0;
      iy_r    <= '0;
      rbase_r <= '0;
      seg_q   <= 1'b0;
      iy_last_q <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      ix_r    <= ix_nxt;
      oc_r    <= oc_nxt;
      cbase_r <= cbase_nxt;
      row_r   <= row_nxt;
      iy_r    <= iy_nxt;
      rbase_r <= rbase_nxt;
      if (cmd.accept) begin
        seg_q     <= in_block && ix_last;
        iy_last_q <= iy_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      iy_first_q <= iy_first;
      rowend_q   <= col_last_blk;
      frmend_q   <= col_last_blk && row_last_blk;
      addr_q     <= oc_r[AW-1:0];
    end
  end

  // running sum of the current row segment inside one block
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pix[l] = SUM_W'(in_tdata[l*PIX_W +: PIX_W] & PIX_MASK);
    end
    rs_nxt = rs_r;
    if (restart) begin
      rs_nxt = '0;
    end else if (cmd.accept && in_block) begin
      for (int l = 0; l < LANES; l++) begin
        rs_nxt[l] = ix_first ? pix[l] : rs_r[l] + pix[l];
      end
    end else if (cmd.col_write || cmd.div_start) begin
      rs_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= '0;
    end else begin
      rs_r <= rs_nxt;
    end
  end

  assign rd_lanes = rd_data;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr_lanes[l] = iy_first_q ? rs_r[l] : rd_lanes[l] + rs_r[l];
      dvd[l]      = (s_eff > SCALE_W'(1)) ? rs_r[l] + rd_lanes[l] : rs_r[l];
    end
    divisor = DIV_W'(s_eff) * DIV_W'(s_eff);
  end

  box_avg_ram #(
    .WIDTH (LANES*SUM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_col_sums (
    .clk   (clk),
    .we    (cmd.col_write),
    .waddr (addr_q),
    .wdata (wr_lanes),
    .re    (cmd.accept),
    .raddr (oc_r[AW-1:0]),
    .rdata (rd_data)
  );

  box_avg_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (divisor),
    .quotient (quot),
    .done     (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int l = 0; l < LANES; l++) begin
        out_data_r[l*PIX_W +: PIX_W] <= quot[l][PIX_W-1:0];
      end
      out_last_r  <= rowend_q;
      out_frame_r <= frmend_q;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_frame_r;

  always_comb begin
    sts.seg_end  = seg_q;
    sts.blk_out  = seg_q && iy_last_q;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

// File: rtl/core/box_avg_ctrl.sv
module box_avg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  box_avg_pkg::sts_t sts,
  output box_avg_pkg::cmd_t cmd
);
  import box_avg_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.blk_out ? ST_DIV : ST_IDLE;
      ST_DIV:  if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_EVAL: begin
        cmd.div_start = sts.blk_out;
        cmd.col_write = sts.seg_end && !sts.blk_out;
      end
      ST_DIV: ;
      ST_OUT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import box_avg_pkg::*;

  localparam int OUT_W_MAX    = 4096;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE       = 40;   // cycles for a pixel still in the memory update
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             frame_end;
  } mean_t;

  typedef enum logic { ROW_REG, ROW_PIXEL } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       idx;
    logic [CFG_W-1:0] value;
    pixel_t           px;
    bit               has_mean;
    mean_t            mean;
  } dir_row_t;

  typedef struct {
    logic [CFG_W-1:0] scale;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    int unsigned      count;
    bit               hot;
  } phase_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [3*PIX_W-1:0]   in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [3*PIX_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic [0:0]           out_tuser;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  box_average_downscaler_core #(
    .MAX_OUT_WIDTH(OUT_W_MAX),
    .PIXEL_BITS   (PIX_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [SCALE_W-1:0] p_scale  = SCALE_RESET;
  logic [DIM_W-1:0]   p_width  = DIM_RESET;
  logic [DIM_W-1:0]   p_height = DIM_RESET;
  int unsigned        col_pos  = 0;
  int unsigned        row_pos  = 0;
  int unsigned        blk_sum [3];
  int unsigned        col_sum [OUT_W_MAX][3];

  mean_t       pending_means [$];
  dir_row_t    dir_rows [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t rand_pixel(bit hot);
    pixel_t px;
    logic [PIX_W-1:0] lane [3];
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 9))
        0:       lane[c] = '0;
        1:       lane[c] = '1;
        default: lane[c] = PIX_W'($urandom());
      endcase
      if (hot) lane[c] = '1;
    end
    px.red   = lane[0];
    px.green = lane[1];
    px.blue  = lane[2];
    return px;
  endfunction

  task automatic apply_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    case (idx)
      CFG_SCALE:  p_scale  = value[SCALE_W-1:0];
      CFG_WIDTH:  p_width  = value[DIM_W-1:0];
      CFG_HEIGHT: p_height = value[DIM_W-1:0];
      default: ;
    endcase
    // an unused index leaves the frame where it is
    if (idx != CFG_SPARE) begin
      col_pos = 0;
      row_pos = 0;
      for (int c = 0; c < 3; c++) blk_sum[c] = 0;
    end
  endtask

  task automatic predict_block_mean(input pixel_t px, output bit produced, output mean_t m);
    int unsigned s, w, h, out_w, out_h, oc, ix, orow, iy, total;
    int unsigned lane_in [3];
    int unsigned lane_mean [3];
    lane_in[0] = 32'(px.red);
    lane_in[1] = 32'(px.green);
    lane_in[2] = 32'(px.blue);
    produced = 1'b0;
    m = '0;
    s = (p_scale == 0) ? 1 : (p_scale > SCALE_MAX) ? SCALE_MAX : p_scale;
    w = (p_width == 0) ? 1 : (p_width > DIM_MAX) ? DIM_MAX : p_width;
    h = (p_height == 0) ? 1 : (p_height > DIM_MAX) ? DIM_MAX : p_height;
    out_w = w / s;
    if (out_w > OUT_W_MAX) out_w = OUT_W_MAX;
    out_h = h / s;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    oc   = col_pos / s;
    ix   = col_pos % s;
    orow = row_pos / s;
    iy   = row_pos % s;
    if (oc < out_w && orow < out_h) begin
      for (int c = 0; c < 3; c++)
        blk_sum[c] = (ix == 0) ? lane_in[c] : blk_sum[c] + lane_in[c];
      if (ix == s - 1) begin
        if (iy == s - 1) begin
          for (int c = 0; c < 3; c++) begin
            total = blk_sum[c];
            if (s > 1) total += col_sum[oc][c];
            lane_mean[c] = total / (s * s);
          end
          m.red       = PIX_W'(lane_mean[0]);
          m.green     = PIX_W'(lane_mean[1]);
          m.blue      = PIX_W'(lane_mean[2]);
          m.row_end   = (oc == out_w - 1);
          m.frame_end = (oc == out_w - 1) && (orow == out_h - 1);
          produced    = 1'b1;
        end else begin
          for (int c = 0; c < 3; c++)
            col_sum[oc][c] = (iy == 0) ? blk_sum[c] : col_sum[oc][c] + blk_sum[c];
        end
        for (int c = 0; c < 3; c++) blk_sum[c] = 0;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input pixel_t px, input bit has_mean, input mean_t typed);
    int unsigned gap;
    bit          taken;
    bit          produced;
    mean_t       m;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {px.blue, px.green, px.red};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    predict_block_mean(px, produced, m);
    if (has_mean) pending_means.push_back(typed);
    else if (produced) pending_means.push_back(m);
  endtask

  // registers only change once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    apply_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input phase_t ph);
    no_idle = ($urandom_range(0, 3) == 0);
    write_reg(CFG_SCALE, ph.scale);
    write_reg(CFG_WIDTH, ph.width);
    write_reg(CFG_HEIGHT, ph.height);
    repeat (ph.count) send_pixel(rand_pixel(ph.hot), 1'b0, '0);
  endtask

  function automatic phase_t fixed_phase(input logic [CFG_W-1:0] scale, width, height,
                                         input int unsigned count, input bit hot);
    phase_t ph;
    ph.scale  = scale;
    ph.width  = width;
    ph.height = height;
    ph.count  = count;
    ph.hot    = hot;
    return ph;
  endfunction

  function automatic phase_t make_phase();
    phase_t      ph;
    int unsigned s, w, h, ew, eh;
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k <= 5) begin
      s = $urandom_range(1, 4);
      w = s * $urandom_range(1, 4) + $urandom_range(0, s);
      h = s * $urandom_range(1, 3) + $urandom_range(0, 1);
      ph.scale = CFG_W'(s);
    end else if (k <= 7) begin
      s = $urandom_range(5, 8);
      w = s * $urandom_range(1, 2) + $urandom_range(0, 2);
      h = s + $urandom_range(0, 1);
      ph.scale = CFG_W'(s);
    end else if (k == 8) begin
      // scale outside its range, with junk above the register width now and then
      if ($urandom_range(0, 1)) begin
        ph.scale = $urandom_range(0, 1) ? 14'h0000 : 14'h3FE0;
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 3);
      end else begin
        ph.scale = CFG_W'($urandom_range(17, 31));
        w = $urandom_range(0, 20);
        h = $urandom_range(16, 17);
      end
    end else begin
      // image smaller than one block in one direction
      s = $urandom_range(2, 8);
      ph.scale = CFG_W'(s);
      if ($urandom_range(0, 1)) begin
        w = $urandom_range(1, s - 1);
        h = $urandom_range(s, 2 * s);
      end else begin
        w = $urandom_range(s, 2 * s);
        h = $urandom_range(1, s - 1);
      end
    end
    ph.width  = CFG_W'(w);
    ph.height = CFG_W'(h);
    ew = (w == 0) ? 1 : w;
    eh = (h == 0) ? 1 : h;
    ph.count = $urandom_range(1, 2) * ew * eh + $urandom_range(0, ew);
    if (ph.count > 150) ph.count = 150;
    ph.hot = ($urandom_range(0, 15) == 0);
    return ph;
  endfunction

  function automatic void dir_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    dir_row_t r;
    r.kind     = ROW_REG;
    r.idx      = idx;
    r.value    = value;
    r.px       = '0;
    r.has_mean = 1'b0;
    r.mean     = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_pix(input logic [PIX_W-1:0] red, green, blue);
    dir_row_t r;
    r.kind     = ROW_PIXEL;
    r.idx      = '0;
    r.value    = '0;
    r.px       = '{blue: blue, green: green, red: red};
    r.has_mean = 1'b0;
    r.mean     = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_mean(input logic [PIX_W-1:0] red, green, blue,
                                   input logic [PIX_W-1:0] m_red, m_green, m_blue,
                                   input logic row_end, frame_end);
    dir_row_t r;
    r.kind     = ROW_PIXEL;
    r.idx      = '0;
    r.value    = '0;
    r.px       = '{blue: blue, green: green, red: red};
    r.has_mean = 1'b1;
    r.mean     = '{blue: m_blue, green: m_green, red: m_red,
                   row_end: row_end, frame_end: frame_end};
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endfunction

  // outputs only move at the rising edge, so the item seen here is taken at the next one
  always @(negedge clk) begin
    mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected item, expected none got %h last %b user %b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = pending_means.pop_front();
        check_field("mean_red",   want.red,       out_tdata[PIX_W-1:0]);
        check_field("mean_green", want.green,     out_tdata[2*PIX_W-1:PIX_W]);
        check_field("mean_blue",  want.blue,      out_tdata[3*PIX_W-1:2*PIX_W]);
        check_field("row_end",    want.row_end,   out_tlast);
        check_field("frame_end",  want.frame_end, out_tuser[0]);
      end
    end
  end

  initial begin : ready_drive
    int unsigned stall;
    int unsigned hold;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold = 1 + $urandom_range(0, 7);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin : stimulus
    phase_t      ph;
    int unsigned random_done;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 8x8 blocks on a 4096 wide image, nothing comes out this early
    dir_pix(16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_pix(16'h0000, 16'h0000, 16'h0000);
    // scale 0 acts as 1: each pixel passes straight through
    dir_reg(CFG_SCALE, 14'd0);
    dir_reg(CFG_WIDTH, 14'd2);
    dir_reg(CFG_HEIGHT, 14'd1);
    dir_mean(16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'h1234, 1'b0, 1'b0);
    dir_reg(CFG_SPARE, 14'h3FFF);   // no register there, frame carries on
    dir_mean(16'h0000, 16'hFFFF, 16'h8001, 16'h0000, 16'hFFFF, 16'h8001, 1'b1, 1'b1);
    dir_mean(16'hA5A5, 16'h5A5A, 16'h0001, 16'hA5A5, 16'h5A5A, 16'h0001, 1'b0, 1'b0);
    // 2x2 at full scale, odd width leaves a dropped column
    dir_reg(CFG_SCALE, 14'd2);
    dir_reg(CFG_WIDTH, 14'd3);
    dir_reg(CFG_HEIGHT, 14'd2);
    dir_pix(16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_pix(16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_pix(16'h0000, 16'h0000, 16'h0000);
    dir_pix(16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_mean(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    dir_pix(16'h0000, 16'h0000, 16'h0000);
    // truncation of the mean
    dir_reg(CFG_WIDTH, 14'd2);
    dir_pix(16'd1, 16'd2, 16'd3);
    dir_pix(16'd0, 16'd1, 16'd2);
    dir_pix(16'd0, 16'd0, 16'd3);
    dir_mean(16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 1'b1, 1'b1);
    // scale above 16, image narrower than a block, height 0
    dir_reg(CFG_SCALE, 14'd31);
    dir_reg(CFG_WIDTH, 14'd15);
    dir_reg(CFG_HEIGHT, 14'd0);
    dir_pix(16'h1234, 16'h5678, 16'h9ABC);
    dir_pix(16'hFFFF, 16'h0000, 16'hFFFF);

    foreach (dir_rows[i]) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].idx, dir_rows[i].value);
      else send_pixel(dir_rows[i].px, dir_rows[i].has_mean, dir_rows[i].mean);
    end

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      ph = make_phase();
      run_phase(ph);
      random_done += ph.count;
    end

    // extremes: largest block with full-scale pixels, wide scale with leftovers,
    // clamped dimensions, single pixel frames
    run_phase(fixed_phase(14'h3FF0, 14'd16, 14'd16, 256, 1'b1));
    run_phase(fixed_phase(14'd12, 14'd13, 14'd12, 156, 1'b0));
    run_phase(fixed_phase(14'd20, 14'h3FFF, 14'h3FFF, 24, 1'b0));
    run_phase(fixed_phase(14'd16, 14'd8192, 14'd8192, 24, 1'b0));
    run_phase(fixed_phase(14'd1, 14'd1, 14'd1, 3, 1'b0));

    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
